@@ sv/gost_cipher_inverse_round_core_defines.svh @@
// Assertion macros used by the checker file of the inverse round core.
`ifndef GOST_CIPHER_INVERSE_ROUND_CORE_DEFINES_SVH
`define GOST_CIPHER_INVERSE_ROUND_CORE_DEFINES_SVH

// Property checked on clk, masked while reset is asserted.
`define GCIR_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Property checked on clk at every edge, reset included.
`define GCIR_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

@@ sv/gcir_pkg.sv @@
// Types, constant tables and GF(2^8) helpers for the inverse round core.
package gcir_pkg;

  localparam int unsigned NumBytes = 16;

  typedef logic [7:0] byte_t;
  typedef byte_t [NumBytes-1:0] row_t;
  typedef row_t [NumBytes-1:0] mat_t;

  // x^8 + x^7 + x^6 + x + 1
  localparam logic [8:0] GfPoly = 9'b111000011;

  localparam byte_t MixCoef [NumBytes] = '{
    8'd148, 8'd32, 8'd133, 8'd16, 8'd194, 8'd192, 8'd1, 8'd251,
    8'd1, 8'd192, 8'd194, 8'd16, 8'd133, 8'd32, 8'd148, 8'd1
  };

  localparam byte_t InvSbox [256] = '{
    8'd165, 8'd45,  8'd50,  8'd143, 8'd14,  8'd48,  8'd56,  8'd192,
    8'd84,  8'd230, 8'd158, 8'd57,  8'd85,  8'd126, 8'd82,  8'd145,
    8'd100, 8'd3,   8'd87,  8'd90,  8'd28,  8'd96,  8'd7,   8'd24,
    8'd33,  8'd114, 8'd168, 8'd209, 8'd41,  8'd198, 8'd164, 8'd63,
    8'd224, 8'd39,  8'd141, 8'd12,  8'd130, 8'd234, 8'd174, 8'd180,
    8'd154, 8'd99,  8'd73,  8'd229, 8'd66,  8'd228, 8'd21,  8'd183,
    8'd200, 8'd6,   8'd112, 8'd157, 8'd65,  8'd117, 8'd25,  8'd201,
    8'd170, 8'd252, 8'd77,  8'd191, 8'd42,  8'd115, 8'd132, 8'd213,
    8'd195, 8'd175, 8'd43,  8'd134, 8'd167, 8'd177, 8'd178, 8'd91,
    8'd70,  8'd211, 8'd159, 8'd253, 8'd212, 8'd15,  8'd156, 8'd47,
    8'd155, 8'd67,  8'd239, 8'd217, 8'd121, 8'd182, 8'd83,  8'd127,
    8'd193, 8'd240, 8'd35,  8'd231, 8'd37,  8'd94,  8'd181, 8'd30,
    8'd162, 8'd223, 8'd166, 8'd254, 8'd172, 8'd34,  8'd249, 8'd226,
    8'd74,  8'd188, 8'd53,  8'd202, 8'd238, 8'd120, 8'd5,   8'd107,
    8'd81,  8'd225, 8'd89,  8'd163, 8'd242, 8'd113, 8'd86,  8'd17,
    8'd106, 8'd137, 8'd148, 8'd101, 8'd140, 8'd187, 8'd119, 8'd60,
    8'd123, 8'd40,  8'd171, 8'd210, 8'd49,  8'd222, 8'd196, 8'd95,
    8'd204, 8'd207, 8'd118, 8'd44,  8'd184, 8'd216, 8'd46,  8'd54,
    8'd219, 8'd105, 8'd179, 8'd20,  8'd149, 8'd190, 8'd98,  8'd161,
    8'd59,  8'd22,  8'd102, 8'd233, 8'd92,  8'd108, 8'd109, 8'd173,
    8'd55,  8'd97,  8'd75,  8'd185, 8'd227, 8'd186, 8'd241, 8'd160,
    8'd133, 8'd131, 8'd218, 8'd71,  8'd197, 8'd176, 8'd51,  8'd250,
    8'd150, 8'd111, 8'd110, 8'd194, 8'd246, 8'd80,  8'd255, 8'd93,
    8'd169, 8'd142, 8'd23,  8'd27,  8'd151, 8'd125, 8'd236, 8'd88,
    8'd247, 8'd31,  8'd251, 8'd124, 8'd9,   8'd13,  8'd122, 8'd103,
    8'd69,  8'd135, 8'd220, 8'd232, 8'd79,  8'd29,  8'd78,  8'd4,
    8'd235, 8'd248, 8'd243, 8'd62,  8'd61,  8'd189, 8'd138, 8'd136,
    8'd221, 8'd205, 8'd11,  8'd19,  8'd152, 8'd2,   8'd147, 8'd128,
    8'd144, 8'd208, 8'd36,  8'd52,  8'd203, 8'd237, 8'd244, 8'd206,
    8'd153, 8'd16,  8'd68,  8'd64,  8'd146, 8'd58,  8'd1,   8'd38,
    8'd18,  8'd26,  8'd72,  8'd104, 8'd245, 8'd129, 8'd139, 8'd199,
    8'd214, 8'd32,  8'd10,  8'd8,   8'd0,   8'd76,  8'd215, 8'd116
  };

  function automatic byte_t gf_mul(input byte_t a, input byte_t b);
    byte_t acc;
    logic [8:0] x;
    acc = '0;
    x = {1'b0, a};
    for (int n = 0; n < 8; n++) begin
      if (b[n]) acc ^= x[7:0];
      x = {x[7:0], 1'b0};
      if (x[8]) x ^= GfPoly;
    end
    return acc;
  endfunction

  // Folds the sixteen feedback steps into one byte matrix: each register
  // byte is tracked as its coefficient row over the sixteen input bytes.
  function automatic mat_t calc_inv_l();
    mat_t b;
    row_t t;
    for (int k = 0; k < NumBytes; k++) begin
      for (int c = 0; c < NumBytes; c++) begin
        b[k][c] = (k == c) ? 8'd1 : 8'd0;
      end
    end
    for (int r = 0; r < NumBytes; r++) begin
      t = '0;
      for (int i = 0; i < NumBytes; i++) begin
        for (int c = 0; c < NumBytes; c++) begin
          t[c] ^= gf_mul(MixCoef[i], b[i][c]);
        end
      end
      for (int i = NumBytes - 1; i > 0; i--) begin
        b[i] = b[i-1];
      end
      b[0] = t;
    end
    return b;
  endfunction

  localparam mat_t InvLMat = calc_inv_l();

endpackage

@@ sv/gcir_lane.sv @@
// One output byte of the inverse linear map: constant multiply-xor row, registered.
module gcir_lane (
  input  logic           clk,
  input  logic           load,
  input  gcir_pkg::row_t blk,
  input  gcir_pkg::row_t coef,
  output gcir_pkg::byte_t mix_r
);
  import gcir_pkg::*;

  byte_t mix_nxt;

  always_comb begin
    mix_nxt = '0;
    for (int i = 0; i < NumBytes; i++) begin
      mix_nxt ^= gf_mul(coef[i], blk[i]);
    end
  end

  always_ff @(posedge clk) begin
    if (load) mix_r <= mix_nxt;
  end

endmodule

@@ sv/gcir_merge.sv @@
// Merge stage: inverse S-box on every lane byte, packed into the output register.
module gcir_merge (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           mix_valid,
  output logic           mix_ready,
  input  gcir_pkg::row_t mix,
  output logic           out_valid,
  input  logic           out_ready,
  output logic [63:0]    out_hi,
  output logic [63:0]    out_lo
);
  import gcir_pkg::*;

  logic           out_valid_r;
  logic [127:0]   blk_r;
  logic [127:0]   blk_nxt;

  assign mix_ready = !out_valid_r || out_ready;

  always_comb begin
    for (int i = 0; i < NumBytes; i++) begin
      blk_nxt[8*i +: 8] = InvSbox[mix[i]];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (mix_ready) begin
      out_valid_r <= mix_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (mix_valid && mix_ready) blk_r <= blk_nxt;
  end

  assign out_valid = out_valid_r;
  assign out_hi    = blk_r[127:64];
  assign out_lo    = blk_r[63:0];

endmodule

@@ sv/gost_cipher_inverse_round_core.sv @@
// Top level of the inverse cipher round: key add, inverse linear map, inverse S-box.
// Accepts one 128-bit block plus round key per cycle while in_ready is high and
// returns the decrypted round result through the lane stage and the output register.
// The first register stage is sixteen byte lanes, each holding one output byte
// of the inverse linear map computed as a constant GF(2^8) multiply-xor row over
// (key xor block); the second is the output register after the inverse S-box.
// Byte 0 is bits 7:0 of the low half. in_ready drops only while a finished
// result is held and the lane stage is also full.
module gost_cipher_inverse_round_core (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [63:0] in_data_hi,
  input  logic [63:0] in_data_lo,
  input  logic [63:0] in_key_hi,
  input  logic [63:0] in_key_lo,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [63:0] out_hi,
  output logic [63:0] out_lo
);
  import gcir_pkg::*;

  logic   s1_valid_r;
  logic   s1_ready;
  logic   s1_load;
  row_t   blk;
  row_t   mix;

  assign blk      = {in_data_hi ^ in_key_hi, in_data_lo ^ in_key_lo};
  assign in_ready = !s1_valid_r || s1_ready;
  assign s1_load  = in_valid && in_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_ready) begin
      s1_valid_r <= in_valid;
    end
  end

  for (genvar j = 0; j < NumBytes; j++) begin : g_lane
    gcir_lane u_lane (
      .clk   (clk),
      .load  (s1_load),
      .blk   (blk),
      .coef  (InvLMat[j]),
      .mix_r (mix[j])
    );
  end

  gcir_merge u_merge (
    .clk       (clk),
    .rst_n     (rst_n),
    .mix_valid (s1_valid_r),
    .mix_ready (s1_ready),
    .mix       (mix),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_hi    (out_hi),
    .out_lo    (out_lo)
  );

endmodule

@@ sv/gcir_checker.sv @@
// Port-level checker for the inverse round core, bound to the top level.
`include "gost_cipher_inverse_round_core_defines.svh"

module gcir_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        in_valid,
  input logic        in_ready,
  input logic        out_valid,
  input logic        out_ready,
  input logic [63:0] out_hi,
  input logic [63:0] out_lo
);

  `GCIR_ASSERT_ALWAYS(a_rst_clears, !rst_n |=> !out_valid, "out_valid set after reset")
  `GCIR_ASSERT(a_hold_valid, out_valid && !out_ready |=> out_valid, "result dropped while stalled")
  `GCIR_ASSERT(a_hold_data, out_valid && !out_ready |=> $stable(out_hi) && $stable(out_lo),
    "result changed while stalled")
  // a request taken must show up at the output register by way of the lane stage
  `GCIR_ASSERT(a_latency, in_valid && in_ready |=> ##1 out_valid, "request lost in pipeline")
  // back pressure only when the output is full and stalled
  `GCIR_ASSERT(a_stall_cause, !in_ready |-> out_valid && !out_ready, "in_ready low without stall")

endmodule

bind gost_cipher_inverse_round_core gcir_checker u_gcir_checker (.*);
